// File: hdl/hexcan_pkg.sv
// Shared types and constants for the hex-text frame parser.
// No dependencies; every file of the block but hexcan_fifo imports this package.
package hexcan_pkg;

  localparam int CMD_CHARS_DEF  = 64;
  localparam int MAX_DIGITS_DEF = 20;

  // Widest digit store a job can carry; queue entries are sized for it.
  localparam int DIGITS_CAP = 20;
  localparam int DCNT_W     = $clog2(DIGITS_CAP + 1);

  localparam int JOBQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  localparam int IDLE_W = 24;
  localparam logic [IDLE_W-1:0] IDLE_MAX   = 24'hFF_FFFF;
  localparam logic [IDLE_W-1:0] IDLE_RESET = 24'd200000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 1'b1;

  localparam logic [1:0] ST_FRAME    = 2'd0;
  localparam logic [1:0] ST_SYNTAX   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [15:0] ID_MAX = 16'h07FF;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] frame_id;
    logic [3:0]  byte_count;
    logic [63:0] frame_data;
  } out_item_t;

  // Finished command handed from the front end to the decoder.
  typedef struct packed {
    logic                        too_long;
    logic                        bad;
    logic [DCNT_W-1:0]           dcount;
    logic [DIGITS_CAP-1:0][3:0]  digits;
  } job_t;

endpackage

// File: hdl/hexcan_fifo.sv
// Small first-in first-out queue of any packed type.
// Depends on nothing but its parameters.
module hexcan_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/hexcan_front.sv
// Front end: configuration registers, per-character classification and the
// digit store; emits one job per finished command. Uses hexcan_pkg.
module hexcan_front #(
  parameter int CMD_CHARS  = hexcan_pkg::CMD_CHARS_DEF,
  parameter int MAX_DIGITS = hexcan_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  input  hexcan_pkg::in_item_t                item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hexcan_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hexcan_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                                job_push,
  output hexcan_pkg::job_t                    job
);
  import hexcan_pkg::*;

  localparam int CC_W  = $clog2(CMD_CHARS);
  localparam int DC_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CC_W-1:0] CHAR_LAST = CC_W'(CMD_CHARS - 1);
  localparam logic [DC_W-1:0] DIG_FULL  = DC_W'(MAX_DIGITS);

  logic              enable_r, enable_nxt;
  logic [IDLE_W-1:0] idle_limit_r, idle_limit_nxt;
  logic [CC_W-1:0]   char_count_r, char_count_nxt;
  logic [DC_W-1:0]   digit_count_r, digit_count_nxt;
  logic              syntax_bad_r, syntax_bad_nxt;
  logic [IDLE_W-1:0] idle_count_r, idle_count_nxt;
  logic [3:0]        digit_store [MAX_DIGITS];

  logic [IDLE_W-1:0] idle_inc;
  logic              is_eol, is_sep, hex_ok;
  logic [3:0]        hex_val;
  logic              finish, too_long, store_we;
  logic [7:0]        c;

  assign cfg_ready = 1'b1;
  assign c         = item.char_code;
  assign is_eol    = (c == 8'h0D) || (c == 8'h0A);
  assign is_sep    = (c == 8'h20) || (c == 8'h09) || (c == 8'h2C) || (c == 8'h3A);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign idle_inc = (idle_count_r == IDLE_MAX) ? idle_count_r : idle_count_r + IDLE_W'(1);

  always_comb begin
    enable_nxt      = enable_r;
    idle_limit_nxt  = idle_limit_r;
    char_count_nxt  = char_count_r;
    digit_count_nxt = digit_count_r;
    syntax_bad_nxt  = syntax_bad_r;
    idle_count_nxt  = idle_count_r;
    finish          = 1'b0;
    too_long        = 1'b0;
    store_we        = 1'b0;

    if (item_valid && enable_r) begin
      if (item.action) begin
        idle_count_nxt = idle_inc;
        if (char_count_r != '0 && idle_inc >= idle_limit_r) begin
          finish = 1'b1;
        end
      end else if (is_eol) begin
        if (char_count_r != '0) begin
          finish = 1'b1;
        end
      end else if (char_count_r != CHAR_LAST) begin
        char_count_nxt = char_count_r + CC_W'(1);
        idle_count_nxt = '0;
        if (!is_sep && !syntax_bad_r) begin
          if (!hex_ok || digit_count_r == DIG_FULL) begin
            syntax_bad_nxt = 1'b1;
          end else begin
            store_we        = 1'b1;
            digit_count_nxt = digit_count_r + DC_W'(1);
          end
        end
      end else begin
        // overlong: drop the character and flush the command
        too_long = 1'b1;
      end
    end

    if (finish || too_long) begin
      char_count_nxt  = '0;
      digit_count_nxt = '0;
      syntax_bad_nxt  = 1'b0;
      idle_count_nxt  = '0;
    end

    if (cfg_valid) begin
      if (cfg_index == CFG_ENABLE) begin
        enable_nxt = cfg_wdata[0];
        if (!cfg_wdata[0]) begin
          char_count_nxt  = '0;
          digit_count_nxt = '0;
          syntax_bad_nxt  = 1'b0;
          idle_count_nxt  = '0;
        end
      end else if (cfg_index == CFG_IDLE_LIMIT) begin
        idle_limit_nxt = cfg_wdata[IDLE_W-1:0];
      end
    end
  end

  // Snapshot the store into the job; slots past MAX_DIGITS read as zero.
  always_comb begin
    job_push      = finish || too_long;
    job.too_long  = too_long;
    job.bad       = syntax_bad_r;
    job.dcount    = DCNT_W'(digit_count_r);
    for (int i = 0; i < DIGITS_CAP; i++) begin
      job.digits[i] = (i < MAX_DIGITS) ? digit_store[(i < MAX_DIGITS) ? i : 0] : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      idle_limit_r  <= IDLE_RESET;
      char_count_r  <= '0;
      digit_count_r <= '0;
      syntax_bad_r  <= 1'b0;
      idle_count_r  <= '0;
    end else begin
      enable_r      <= enable_nxt;
      idle_limit_r  <= idle_limit_nxt;
      char_count_r  <= char_count_nxt;
      digit_count_r <= digit_count_nxt;
      syntax_bad_r  <= syntax_bad_nxt;
      idle_count_r  <= idle_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[digit_count_r[IDX_W-1:0]] <= hex_val;
    end
  end

endmodule

// File: hdl/hexcan_back.sv
// Back end: decodes one job per cycle, when the output queue has room,
// into a result queued for the receiver. Uses hexcan_pkg and hexcan_fifo.
module hexcan_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  hexcan_pkg::job_t      job,
  output logic                  job_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output hexcan_pkg::out_item_t out_data
);
  import hexcan_pkg::*;

  out_item_t         res;
  logic              outq_full;
  logic [15:0]       id16;
  logic [DCNT_W-1:0] rest;
  logic [3:0]        nbytes;
  logic              ok;
  logic [63:0]       data;

  assign job_pop = job_valid && !outq_full;

  assign id16   = {job.digits[0], job.digits[1], job.digits[2], job.digits[3]};
  assign rest   = job.dcount - DCNT_W'(4);
  assign nbytes = 4'(rest >> 1);

  always_comb begin
    ok = !job.bad && (job.dcount >= DCNT_W'(4));
    if (id16 > ID_MAX || rest[0] || nbytes > 4'd8) begin
      ok = 1'b0;
    end
    data = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes) begin
        data[8*i +: 8] = {job.digits[4 + 2*i], job.digits[5 + 2*i]};
      end
    end
    res = '0;
    if (job.too_long) begin
      res.status = ST_TOO_LONG;
    end else if (!ok) begin
      res.status = ST_SYNTAX;
    end else begin
      res.status     = ST_FRAME;
      res.frame_id   = id16[10:0];
      res.byte_count = nbytes;
      res.frame_data = data;
    end
  end

  hexcan_fifo #(
    .T     (out_item_t),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_pop),
    .push_data (res),
    .full      (outq_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

// File: hdl/hex_text_can_frame_parser.sv
// Hex-text command parser producing standard-identifier frames.
// Top level: front end, job queue and decoder. Uses hexcan_pkg.
//
// Usage:
//   Input is a queue push side: in_data carries action (0 = character,
//   1 = time tick) and char_code; a word is taken when in_push is high and
//   in_full is low. One word can be taken every cycle while in_full is low.
//   Results form a queue pop side: while out_empty is low the oldest result
//   (status, frame_id, byte_count, frame_data) is on out_data, and it is
//   taken when out_pop is high.
//   Configuration: cfg_index 0 = enable, 1 = idle_limit; a write happens when
//   cfg_valid and cfg_ready are high (cfg_ready is always high). Write only
//   while the block is idle.
// A word that ends a command pushes a job into the job queue; the decoder
//   then writes its result into the output queue, whose head is out_data.
//   Throughput: one word per cycle while in_full is low, that is while the
//   job queue is not full.
// Reset clears both queues and the command buffer, disables input and sets
//   idle_limit to 200000. When the receiver stalls, results pile up in the
//   output and job queues; once the job queue is full, in_full rises.
module hex_text_can_frame_parser #(
  parameter int CMD_CHARS  = hexcan_pkg::CMD_CHARS_DEF,
  parameter int MAX_DIGITS = hexcan_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  hexcan_pkg::in_item_t              in_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output hexcan_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hexcan_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hexcan_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hexcan_pkg::*;

  logic item_valid;
  logic job_push, job_pop, jobq_empty;
  job_t job_in, job_out;

  assign item_valid = in_push && !in_full;

  hexcan_front #(
    .CMD_CHARS  (CMD_CHARS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .job_push   (job_push),
    .job        (job_in)
  );

  // Any taken word may finish a command, so hold input while the queue is full.
  hexcan_fifo #(
    .T     (job_t),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (in_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (jobq_empty)
  );

  hexcan_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!jobq_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: hdl/hexcan_chk.sv
// Port-level checks for the hex-text frame parser, bound to the top level.
// Uses hexcan_pkg.
module hexcan_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_empty,
  input logic                  out_pop,
  input hexcan_pkg::out_item_t out_data
);
  import hexcan_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.status == ST_FRAME || out_data.status == ST_SYNTAX ||
                    out_data.status == ST_TOO_LONG))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != ST_FRAME) |->
      (out_data.frame_id == '0 && out_data.byte_count == '0 && out_data.frame_data == '0))
    else $error("error result carries frame fields");

  a_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status == ST_FRAME) |->
      (out_data.byte_count <= 4'd8 &&
       (out_data.frame_data >> (out_data.byte_count * 8)) == '0))
    else $error("frame byte count or unused data bytes wrong");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind hex_text_can_frame_parser hexcan_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
